// ===== src/rplc_pkg.sv =====
// ----------------------------------------------------------------------------
// rplc_pkg: shared constants for the piecewise-linear colour curve block
// Register indexes, reset value of the knee registers and channel widths.
// ----------------------------------------------------------------------------
package rplc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned IndexW  = 3;

  localparam logic [WordW-1:0] KneeReset   = 32'hFFC0_8040;
  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] RegRedX   = 3'd0;
  localparam logic [IndexW-1:0] RegRedY   = 3'd1;
  localparam logic [IndexW-1:0] RegGreenX = 3'd2;
  localparam logic [IndexW-1:0] RegGreenY = 3'd3;
  localparam logic [IndexW-1:0] RegBlueX  = 3'd4;
  localparam logic [IndexW-1:0] RegBlueY  = 3'd5;

endpackage

// ===== src/rgb_piecewise_linear_curve_core.sv =====
// ----------------------------------------------------------------------------
// rgb_piecewise_linear_curve_core: per-channel tone curve on ARGB pixels
// Maps red, green and blue through their own five-segment curves.
// ----------------------------------------------------------------------------
// Usage. Pixels arrive on the input channel (in_valid_i, in_stall_o,
// pixel_in_i) and leave on the output channel (out_valid_o, out_stall_i,
// pixel_out_o); a word moves when valid is high and stall is low. Alpha of
// the input is ignored and the output alpha is always opaque.
// It takes one word per clock unless stalled, holding up to seven in flight.
// A word passes the segment search in the cycle that accepts it, then the
// multiplication, the divider stages (two quotient bits per stage) and the
// offset, clamp and output register, each stage registered in turn.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle, so nothing is lost or repeated; while
// the output register is empty the pipeline keeps moving.
// Reset clears all valid bits and loads every knee register with knees at
// 64, 128, 192 and 255 mapped to themselves, which is the identity curve.
// The six knee registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; indexes above five are ignored. The user must write them
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rgb_piecewise_linear_curve_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  pixel_out_o,
  input  logic                         cfg_we_i,
  input  logic [rplc_pkg::IndexW-1:0]  cfg_index_i,
  input  logic [rplc_pkg::WordW-1:0]   cfg_data_i
);

  logic [rplc_pkg::WordW-1:0] knee_q [rplc_pkg::NumRegs];
  logic [6:0]                 vld_q;
  logic                       en;
  logic [7:0]                 red, green, blue;
  logic [31:0]                pixel_out_q;

  // The pipeline moves unless a finished word is held back by the receiver.
  assign en         = !(vld_q[6] && out_stall_i);
  assign in_stall_o = !en;

  // Knee registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rplc_pkg::NumRegs; i++) begin
        knee_q[i] <= rplc_pkg::KneeReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rplc_pkg::RegRedX:   knee_q[0] <= cfg_data_i;
        rplc_pkg::RegRedY:   knee_q[1] <= cfg_data_i;
        rplc_pkg::RegGreenX: knee_q[2] <= cfg_data_i;
        rplc_pkg::RegGreenY: knee_q[3] <= cfg_data_i;
        rplc_pkg::RegBlueX:  knee_q[4] <= cfg_data_i;
        rplc_pkg::RegBlueY:  knee_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits run alongside the data stages of the channel units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  rplc_channel u_red (
    .clk_i    (clk_i),
    .en_i     (en),
    .value_i  (pixel_in_i[23:16]),
    .knee_x_i (knee_q[0]),
    .knee_y_i (knee_q[1]),
    .result_o (red)
  );

  rplc_channel u_green (
    .clk_i    (clk_i),
    .en_i     (en),
    .value_i  (pixel_in_i[15:8]),
    .knee_x_i (knee_q[2]),
    .knee_y_i (knee_q[3]),
    .result_o (green)
  );

  rplc_channel u_blue (
    .clk_i    (clk_i),
    .en_i     (en),
    .value_i  (pixel_in_i[7:0]),
    .knee_x_i (knee_q[4]),
    .knee_y_i (knee_q[5]),
    .result_o (blue)
  );

  // Output register; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_out_q <= {rplc_pkg::AlphaOpaque, red, green, blue};
    end
  end

  assign out_valid_o = vld_q[6];
  assign pixel_out_o = pixel_out_q;

endmodule

// ===== src/rplc_channel.sv =====
// ----------------------------------------------------------------------------
// rplc_channel: one colour channel through a five-segment curve
// Segment search, multiply, a four-stage radix-4 restoring divider and the
// final offset and clamp. Six register stages; all advance on en_i.
// ----------------------------------------------------------------------------
module rplc_channel (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rplc_pkg::ChanW-1:0] value_i,
  input  logic [rplc_pkg::WordW-1:0] knee_x_i,
  input  logic [rplc_pkg::WordW-1:0] knee_y_i,
  output logic [rplc_pkg::ChanW-1:0] result_o
);

  typedef struct packed {
    logic [15:0] work;
    logic [7:0]  den;
    logic        neg;
    logic [7:0]  yl;
    logic [7:0]  yh;
    logic        zden;
  } div_t;

  typedef struct packed {
    logic [7:0] dv;
    logic [7:0] den;
    logic [7:0] mag;
    logic       neg;
    logic [7:0] yl;
    logic [7:0] yh;
    logic       zden;
  } seg_t;

  // One restoring step: the top byte stays below the divisor throughout.
  function automatic div_t div_step(input div_t s);
    div_t       r;
    logic [8:0] t;
    r = s;
    t = {s.work[15:8], s.work[7]};
    if (t >= {1'b0, s.den}) begin
      r.work = {8'(t - {1'b0, s.den}), s.work[6:0], 1'b1};
    end else begin
      r.work = {t[7:0], s.work[6:0], 1'b0};
    end
    return r;
  endfunction

  logic [7:0] px [6];
  logic [7:0] py [6];
  logic [7:0] xl, xh, yl, yh;
  logic       found;
  seg_t       seg_d, seg_q;
  div_t       div_q [5];
  div_t       prod_d;
  logic [9:0] sum;

  // Stage one: pick the first segment that holds the value.
  always_comb begin
    px[0] = '0;
    py[0] = '0;
    for (int k = 0; k < 4; k++) begin
      px[k+1] = knee_x_i[8*k +: 8];
      py[k+1] = knee_y_i[8*k +: 8];
    end
    px[5] = 8'hFF;
    py[5] = 8'hFF;

    xl    = px[4];
    xh    = px[5];
    yl    = py[4];
    yh    = py[5];
    found = 1'b0;
    if (value_i <= px[1]) begin
      xl    = px[0];
      xh    = px[1];
      yl    = py[0];
      yh    = py[1];
      found = 1'b1;
    end
    for (int k = 1; k < 5; k++) begin
      if (!found && value_i > px[k] && value_i <= px[k+1]) begin
        xl    = px[k];
        xh    = px[k+1];
        yl    = py[k];
        yh    = py[k+1];
        found = 1'b1;
      end
    end

    seg_d.dv   = value_i - xl;
    seg_d.den  = xh - xl;
    seg_d.zden = (xh <= xl);
    seg_d.neg  = (yh < yl);
    seg_d.mag  = seg_d.neg ? (yl - yh) : (yh - yl);
    seg_d.yl   = yl;
    seg_d.yh   = yh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  // Stage two: the segment's output rise magnitude times the distance into it.
  always_comb begin
    prod_d.work = 16'(seg_q.mag * seg_q.dv);
    prod_d.den  = seg_q.den;
    prod_d.neg  = seg_q.neg;
    prod_d.yl   = seg_q.yl;
    prod_d.yh   = seg_q.yh;
    prod_d.zden = seg_q.zden;
  end

  // Product register, then stages three to six: two quotient bits per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0] <= prod_d;
      for (int i = 0; i < 4; i++) begin
        div_q[i+1] <= div_step(div_step(div_q[i]));
      end
    end
  end

  // Apply the sign, add the segment's lower output and clamp; a segment with no width gives yh.
  always_comb begin
    if (div_q[4].neg) begin
      sum = {2'b00, div_q[4].yl} - {2'b00, div_q[4].work[7:0]};
    end else begin
      sum = {2'b00, div_q[4].yl} + {2'b00, div_q[4].work[7:0]};
    end
    if (div_q[4].zden) begin
      result_o = div_q[4].yh;
    end else if (sum[9]) begin
      result_o = '0;
    end else if (sum[8]) begin
      result_o = 8'hFF;
    end else begin
      result_o = sum[7:0];
    end
  end

endmodule
